[src/hsv2rgb_pkg.sv]
package hsv2rgb_pkg;

  localparam int unsigned PERCENT_MAX = 100;

  localparam int unsigned W_PCT_IN = 7;
  localparam int unsigned W_HUE    = 9;
  localparam int unsigned W_CH     = 8;
  localparam int unsigned W_DATA   = 32;
  localparam int unsigned W_ADDR   = 3;

  localparam int unsigned HUE_WRAP   = 360;
  localparam int unsigned SECTOR_DEG = 60;
  localparam int unsigned CH_MAX     = 255;

  localparam int unsigned W_PCT  = $clog2(PERCENT_MAX + 1);
  localparam int unsigned W_VS   = $clog2(PERCENT_MAX * PERCENT_MAX + 1);
  localparam int unsigned DENOM  = SECTOR_DEG * PERCENT_MAX * PERCENT_MAX;
  localparam int unsigned V_SCALE = SECTOR_DEG * PERCENT_MAX;
  localparam int unsigned W_T    = $clog2(DENOM + 1);
  localparam int unsigned W_U    = $clog2(DENOM * CH_MAX + 1);
  localparam longint unsigned RECIP = (64'd1 << W_U) / DENOM;
  localparam int unsigned W_RC   = $clog2(RECIP + 1);
  localparam int unsigned W_SEC  = 3;
  localparam int unsigned W_FRAC = $clog2(SECTOR_DEG + 1);

  localparam int unsigned NSTG = 5;

  localparam logic [W_ADDR-3:0] IDX_HUE = (W_ADDR - 2)'(0);

  typedef enum logic [W_SEC-1:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_t;

  typedef struct packed {
    sector_t            sector;
    logic [W_FRAC-1:0]  frac;
  } hue_dec_t;

  typedef struct packed {
    logic [W_PCT_IN-1:0] saturation;
    logic [W_PCT_IN-1:0] brightness;
  } in_data_t;

  typedef struct packed {
    logic [W_CH-1:0] red;
    logic [W_CH-1:0] green;
    logic [W_CH-1:0] blue;
  } out_data_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } mix_en_t;

  typedef struct packed {
    logic s4;
    logic s5;
  } scale_en_t;

  function automatic logic [W_PCT-1:0] pct_clamp(input logic [W_PCT_IN-1:0] p);
    if (32'(p) > PERCENT_MAX) begin
      return W_PCT'(PERCENT_MAX);
    end else begin
      return W_PCT'(p);
    end
  endfunction

endpackage

[src/hsv2rgb_regs.sv]
module hsv2rgb_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [hsv2rgb_pkg::W_ADDR-1:0]     paddr,
  input  logic [hsv2rgb_pkg::W_DATA-1:0]     pwdata,
  output logic [hsv2rgb_pkg::W_DATA-1:0]     prdata,
  output logic                               pready,
  output hsv2rgb_pkg::hue_dec_t              hue_dec
);

  logic [hsv2rgb_pkg::W_HUE-1:0]  hue_r;
  logic [hsv2rgb_pkg::W_HUE-1:0]  hue_wrap;
  logic [hsv2rgb_pkg::W_HUE-1:0]  base;
  logic [hsv2rgb_pkg::W_FRAC-1:0] sec_off;
  hsv2rgb_pkg::sector_t           sector;
  logic                           hit_hue;

  assign pready  = 1'b1;
  assign hit_hue = (paddr[hsv2rgb_pkg::W_ADDR-1:2] == hsv2rgb_pkg::IDX_HUE);
  assign prdata  = hit_hue ? hsv2rgb_pkg::W_DATA'(hue_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_r <= '0;
    end else if (psel && penable && pwrite && pready && hit_hue) begin
      hue_r <= pwdata[hsv2rgb_pkg::W_HUE-1:0];
    end
  end

  always_comb begin
    hue_wrap = (32'(hue_r) >= hsv2rgb_pkg::HUE_WRAP) ?
               hue_r - hsv2rgb_pkg::W_HUE'(hsv2rgb_pkg::HUE_WRAP) : hue_r;
    priority if (32'(hue_wrap) < 1 * hsv2rgb_pkg::SECTOR_DEG) begin
      sector = hsv2rgb_pkg::SEC_RY;
      base   = '0;
    end else if (32'(hue_wrap) < 2 * hsv2rgb_pkg::SECTOR_DEG) begin
      sector = hsv2rgb_pkg::SEC_YG;
      base   = hsv2rgb_pkg::W_HUE'(1 * hsv2rgb_pkg::SECTOR_DEG);
    end else if (32'(hue_wrap) < 3 * hsv2rgb_pkg::SECTOR_DEG) begin
      sector = hsv2rgb_pkg::SEC_GC;
      base   = hsv2rgb_pkg::W_HUE'(2 * hsv2rgb_pkg::SECTOR_DEG);
    end else if (32'(hue_wrap) < 4 * hsv2rgb_pkg::SECTOR_DEG) begin
      sector = hsv2rgb_pkg::SEC_CB;
      base   = hsv2rgb_pkg::W_HUE'(3 * hsv2rgb_pkg::SECTOR_DEG);
    end else if (32'(hue_wrap) < 5 * hsv2rgb_pkg::SECTOR_DEG) begin
      sector = hsv2rgb_pkg::SEC_BM;
      base   = hsv2rgb_pkg::W_HUE'(4 * hsv2rgb_pkg::SECTOR_DEG);
    end else begin
      sector = hsv2rgb_pkg::SEC_MR;
      base   = hsv2rgb_pkg::W_HUE'(5 * hsv2rgb_pkg::SECTOR_DEG);
    end
    sec_off = hsv2rgb_pkg::W_FRAC'(hue_wrap - base);
    hue_dec.sector = sector;
    hue_dec.frac   = sector[0] ?
                     hsv2rgb_pkg::W_FRAC'(hsv2rgb_pkg::SECTOR_DEG) - sec_off : sec_off;
  end

endmodule

[src/hsv2rgb_mix.sv]
module hsv2rgb_mix (
  input  logic                           clk,
  input  hsv2rgb_pkg::mix_en_t           en,
  input  hsv2rgb_pkg::in_data_t          in_data,
  input  hsv2rgb_pkg::hue_dec_t          hue_dec,
  output logic [hsv2rgb_pkg::W_U-1:0]    u_red,
  output logic [hsv2rgb_pkg::W_U-1:0]    u_green,
  output logic [hsv2rgb_pkg::W_U-1:0]    u_blue
);

  logic [hsv2rgb_pkg::W_PCT-1:0] s_c;
  logic [hsv2rgb_pkg::W_PCT-1:0] v_c;
  logic [hsv2rgb_pkg::W_VS-1:0]  vs_nxt;

  logic [hsv2rgb_pkg::W_VS-1:0]  vs1_r;
  logic [hsv2rgb_pkg::W_PCT-1:0] v1_r;
  hsv2rgb_pkg::hue_dec_t         dec1_r;

  logic [hsv2rgb_pkg::W_T-1:0]   c_nxt;
  logic [hsv2rgb_pkg::W_T-1:0]   x_nxt;
  logic [hsv2rgb_pkg::W_T-1:0]   vfull;
  logic [hsv2rgb_pkg::W_T-1:0]   m_nxt;

  logic [hsv2rgb_pkg::W_T-1:0]   c2_r;
  logic [hsv2rgb_pkg::W_T-1:0]   x2_r;
  logic [hsv2rgb_pkg::W_T-1:0]   m2_r;
  hsv2rgb_pkg::sector_t          sec2_r;

  logic [hsv2rgb_pkg::W_T-1:0]   comp_r;
  logic [hsv2rgb_pkg::W_T-1:0]   comp_g;
  logic [hsv2rgb_pkg::W_T-1:0]   comp_b;
  logic [hsv2rgb_pkg::W_T-1:0]   t_r;
  logic [hsv2rgb_pkg::W_T-1:0]   t_g;
  logic [hsv2rgb_pkg::W_T-1:0]   t_b;

  logic [hsv2rgb_pkg::W_U-1:0]   ur3_r;
  logic [hsv2rgb_pkg::W_U-1:0]   ug3_r;
  logic [hsv2rgb_pkg::W_U-1:0]   ub3_r;

  always_comb begin
    s_c    = hsv2rgb_pkg::pct_clamp(in_data.saturation);
    v_c    = hsv2rgb_pkg::pct_clamp(in_data.brightness);
    vs_nxt = hsv2rgb_pkg::W_VS'(hsv2rgb_pkg::W_VS'(v_c) * hsv2rgb_pkg::W_VS'(s_c));
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      vs1_r  <= vs_nxt;
      v1_r   <= v_c;
      dec1_r <= hue_dec;
    end
  end

  always_comb begin
    c_nxt = hsv2rgb_pkg::W_T'(vs1_r) * hsv2rgb_pkg::W_T'(hsv2rgb_pkg::SECTOR_DEG);
    x_nxt = hsv2rgb_pkg::W_T'(vs1_r) * hsv2rgb_pkg::W_T'(dec1_r.frac);
    vfull = hsv2rgb_pkg::W_T'(v1_r) * hsv2rgb_pkg::W_T'(hsv2rgb_pkg::V_SCALE);
    m_nxt = vfull - c_nxt;
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      c2_r   <= c_nxt;
      x2_r   <= x_nxt;
      m2_r   <= m_nxt;
      sec2_r <= dec1_r.sector;
    end
  end

  always_comb begin
    unique case (sec2_r)
      hsv2rgb_pkg::SEC_RY: begin
        comp_r = c2_r; comp_g = x2_r; comp_b = '0;
      end
      hsv2rgb_pkg::SEC_YG: begin
        comp_r = x2_r; comp_g = c2_r; comp_b = '0;
      end
      hsv2rgb_pkg::SEC_GC: begin
        comp_r = '0;   comp_g = c2_r; comp_b = x2_r;
      end
      hsv2rgb_pkg::SEC_CB: begin
        comp_r = '0;   comp_g = x2_r; comp_b = c2_r;
      end
      hsv2rgb_pkg::SEC_BM: begin
        comp_r = x2_r; comp_g = '0;   comp_b = c2_r;
      end
      default: begin
        comp_r = c2_r; comp_g = '0;   comp_b = x2_r;
      end
    endcase
    t_r = comp_r + m2_r;
    t_g = comp_g + m2_r;
    t_b = comp_b + m2_r;
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      ur3_r <= hsv2rgb_pkg::W_U'(t_r) * hsv2rgb_pkg::W_U'(hsv2rgb_pkg::CH_MAX);
      ug3_r <= hsv2rgb_pkg::W_U'(t_g) * hsv2rgb_pkg::W_U'(hsv2rgb_pkg::CH_MAX);
      ub3_r <= hsv2rgb_pkg::W_U'(t_b) * hsv2rgb_pkg::W_U'(hsv2rgb_pkg::CH_MAX);
    end
  end

  assign u_red   = ur3_r;
  assign u_green = ug3_r;
  assign u_blue  = ub3_r;

endmodule

[src/hsv2rgb_scale.sv]
module hsv2rgb_scale (
  input  logic                           clk,
  input  hsv2rgb_pkg::scale_en_t         en,
  input  logic [hsv2rgb_pkg::W_U-1:0]    u_in,
  output logic [hsv2rgb_pkg::W_CH-1:0]   q_out
);

  localparam int unsigned W_P = hsv2rgb_pkg::W_U + hsv2rgb_pkg::W_RC;

  logic [W_P-1:0]                  prod;
  logic [hsv2rgb_pkg::W_CH-1:0]    qe_nxt;
  logic [hsv2rgb_pkg::W_CH-1:0]    qe4_r;
  logic [hsv2rgb_pkg::W_U-1:0]     u4_r;
  logic [hsv2rgb_pkg::W_U-1:0]     back;
  logic [hsv2rgb_pkg::W_U-1:0]     rem;
  logic [hsv2rgb_pkg::W_CH-1:0]    q_nxt;
  logic [hsv2rgb_pkg::W_CH-1:0]    q5_r;

  // The reciprocal estimate is low by at most one; the remainder check fixes it.
  always_comb begin
    prod   = W_P'(u_in) * W_P'(hsv2rgb_pkg::RECIP);
    qe_nxt = hsv2rgb_pkg::W_CH'(prod >> hsv2rgb_pkg::W_U);
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      qe4_r <= qe_nxt;
      u4_r  <= u_in;
    end
  end

  always_comb begin
    back  = hsv2rgb_pkg::W_U'(qe4_r) * hsv2rgb_pkg::W_U'(hsv2rgb_pkg::DENOM);
    rem   = u4_r - back;
    q_nxt = (rem >= hsv2rgb_pkg::W_U'(hsv2rgb_pkg::DENOM)) ? qe4_r + 1'b1 : qe4_r;
  end

  always_ff @(posedge clk) begin
    if (en.s5) begin
      q5_r <= q_nxt;
    end
  end

  assign q_out = q5_r;

endmodule

[src/hsv_to_rgb_pixel.sv]
// Channel   Ports                             Direction  Content
// input     in_valid, in_ready, in_data       in         saturation, brightness
// result    out_valid, out_ready, out_data    out        red, green, blue
// config    psel, penable, pwrite, paddr,     in/out     hue register at address 0
//           pwdata, prdata, pready
//
// A transaction passes from input to output through the five-stage multiply
// and divide pipeline; a transaction can enter every cycle unless the output stalls.
// Reset is synchronous and active low; it empties the pipeline and clears hue.
// Each stage moves forward when it is empty or the next stage moves, so a
// stalled output holds while earlier empty stages still fill.
module hsv_to_rgb_pixel (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  hsv2rgb_pkg::in_data_t             in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output hsv2rgb_pkg::out_data_t            out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [hsv2rgb_pkg::W_ADDR-1:0]    paddr,
  input  logic [hsv2rgb_pkg::W_DATA-1:0]    pwdata,
  output logic [hsv2rgb_pkg::W_DATA-1:0]    prdata,
  output logic                              pready
);

  logic [hsv2rgb_pkg::NSTG-1:0] vld_r;
  logic [hsv2rgb_pkg::NSTG-1:0] vld_nxt;
  logic [hsv2rgb_pkg::NSTG-1:0] adv;
  hsv2rgb_pkg::hue_dec_t        hue_dec;
  hsv2rgb_pkg::mix_en_t         mix_en;
  hsv2rgb_pkg::scale_en_t       scale_en;
  logic [hsv2rgb_pkg::W_U-1:0]  u_red;
  logic [hsv2rgb_pkg::W_U-1:0]  u_green;
  logic [hsv2rgb_pkg::W_U-1:0]  u_blue;

  always_comb begin
    adv[hsv2rgb_pkg::NSTG-1] = !vld_r[hsv2rgb_pkg::NSTG-1] || out_ready;
    for (int i = hsv2rgb_pkg::NSTG - 2; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
    vld_nxt = vld_r;
    if (adv[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int i = 1; i < hsv2rgb_pkg::NSTG; i++) begin
      if (adv[i]) begin
        vld_nxt[i] = vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld_r[hsv2rgb_pkg::NSTG-1];

  assign mix_en.s1   = adv[0];
  assign mix_en.s2   = adv[1];
  assign mix_en.s3   = adv[2];
  assign scale_en.s4 = adv[3];
  assign scale_en.s5 = adv[4];

  hsv2rgb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .hue_dec (hue_dec)
  );

  hsv2rgb_mix u_mix (
    .clk     (clk),
    .en      (mix_en),
    .in_data (in_data),
    .hue_dec (hue_dec),
    .u_red   (u_red),
    .u_green (u_green),
    .u_blue  (u_blue)
  );

  hsv2rgb_scale u_scale_red (
    .clk   (clk),
    .en    (scale_en),
    .u_in  (u_red),
    .q_out (out_data.red)
  );

  hsv2rgb_scale u_scale_green (
    .clk   (clk),
    .en    (scale_en),
    .u_in  (u_green),
    .q_out (out_data.green)
  );

  hsv2rgb_scale u_scale_blue (
    .clk   (clk),
    .en    (scale_en),
    .u_in  (u_blue),
    .q_out (out_data.blue)
  );

`ifndef SYNTH
  a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("Input stalled while the output stage is empty.");

  a_enter_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld_r[0])
    else $error("Accepted transaction did not enter the first stage.");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !vld_r[hsv2rgb_pkg::NSTG-2] |=> !out_valid)
    else $error("Output transaction repeated after it was taken.");
`endif

endmodule
